// File: hdl/quaternion_to_euler_angles_top_assert.svh
// assertion macros for the quaternion to euler angle block
// used by the port checker, expects aclk and aresetn in scope
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qte checker: implication failed");

// next-cycle implication, disabled during reset
`define QTE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qte checker: next-cycle implication failed");

`endif

// File: hdl/qte_pkg.sv
// shared types, widths, constants and the cordic arctangent table
// no dependencies
package qte_pkg;

    localparam int QUAT_W          = 16;
    localparam int ANG_W           = 16;
    localparam int ACC_W           = 36;  // q.28 sums, |v| < 2^35
    localparam int MUL_W           = 29;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int CRD_W           = 37;  // cordic x/y with gain headroom
    localparam int Z_W             = 33;  // angle accumulator, 2^31 = pi
    localparam int ROOT_W          = 29;
    localparam int RAD_W           = 2 * ROOT_W;
    localparam int REM_W           = ROOT_W + 2;
    localparam int SQRT_STEPS      = ROOT_W;
    localparam int ATAN_IDX_W      = 5;
    localparam int TERM_W          = 4;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic signed [ACC_W-1:0] ONE_Q28    = ACC_W'(64'sd268435456);
    localparam logic signed [Z_W-1:0]   Z_HALF_PI  = Z_W'(64'sd1073741824);
    localparam logic signed [Z_W-1:0]   BAM_ROUND  = Z_W'(64'sd32768);
    localparam logic signed [Z_W-1:0]   Z_ANG_MAX  = Z_W'(64'sd16384);
    localparam logic signed [ANG_W-1:0] ANG_PI_2   = ANG_W'(32'sd16384);
    localparam logic [RAD_W-1:0]        RAD_ONE    = RAD_W'(1) << 56;

    // product terms, in issue order
    typedef enum logic [TERM_W-1:0] {
        TERM_WX   = 4'd0,
        TERM_YZ   = 4'd1,
        TERM_XX   = 4'd2,
        TERM_ZZ_X = 4'd3,
        TERM_WY   = 4'd4,
        TERM_XZ   = 4'd5,
        TERM_YY   = 4'd6,
        TERM_ZZ_Y = 4'd7,
        TERM_WZ   = 4'd8,
        TERM_YX   = 4'd9,
        TERM_SS   = 4'd10
    } term_t;

    // which angle the cordic is working on
    typedef enum logic [1:0] {
        SRC_X = 2'd0,
        SRC_Y = 2'd1,
        SRC_Z = 2'd2
    } src_t;

    typedef struct packed {
        logic                  load;
        logic                  mul_en;
        term_t                 term;
        logic                  crd_load;
        logic                  crd_step;
        src_t                  src;
        logic [ATAN_IDX_W-1:0] iter;
        logic                  sqrt_load;
        logic                  sqrt_step;
        logic                  res_save;
        logic                  res_sat;
    } dp_cmd_t;

    typedef struct packed {
        logic asin_sat;
    } dp_stat_t;

    // atan(2^-i), 2^31 = pi
    function automatic logic signed [Z_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(64'sd536870912);
            5'd1:    v = Z_W'(64'sd316933406);
            5'd2:    v = Z_W'(64'sd167458907);
            5'd3:    v = Z_W'(64'sd85004756);
            5'd4:    v = Z_W'(64'sd42667331);
            5'd5:    v = Z_W'(64'sd21354465);
            5'd6:    v = Z_W'(64'sd10679838);
            5'd7:    v = Z_W'(64'sd5340245);
            5'd8:    v = Z_W'(64'sd2670163);
            5'd9:    v = Z_W'(64'sd1335087);
            5'd10:   v = Z_W'(64'sd667544);
            5'd11:   v = Z_W'(64'sd333772);
            5'd12:   v = Z_W'(64'sd166886);
            5'd13:   v = Z_W'(64'sd83443);
            5'd14:   v = Z_W'(64'sd41722);
            5'd15:   v = Z_W'(64'sd20861);
            5'd16:   v = Z_W'(64'sd10430);
            5'd17:   v = Z_W'(64'sd5215);
            5'd18:   v = Z_W'(64'sd2608);
            5'd19:   v = Z_W'(64'sd1304);
            5'd20:   v = Z_W'(64'sd652);
            5'd21:   v = Z_W'(64'sd326);
            5'd22:   v = Z_W'(64'sd163);
            5'd23:   v = Z_W'(64'sd81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/qte_isqrt.sv
// bit-pair restoring integer square root, one result bit per step
// depends on qte_pkg
module qte_isqrt (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  logic [qte_pkg::RAD_W-1:0]   rad_in,
    output logic [qte_pkg::ROOT_W-1:0]  root
);
    import qte_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_t;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign rem_t = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = (rem_t >= trial);

    always_ff @(posedge aclk) begin
        if (load) begin
            rad_reg  <= rad_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (step) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= REM_W'(rem_t - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(rem_t);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;

endmodule

// File: hdl/qte_cordic.sv
// vectoring cordic for atan2, one micro-rotation per step
// depends on qte_pkg
module qte_cordic (
    input  logic                                aclk,
    input  logic                                load,
    input  logic                                step,
    input  logic [qte_pkg::ATAN_IDX_W-1:0]      iter,
    input  logic signed [qte_pkg::ACC_W-1:0]    y_in,
    input  logic signed [qte_pkg::ACC_W-1:0]    x_in,
    output logic signed [qte_pkg::Z_W-1:0]      z_out
);
    import qte_pkg::*;

    logic signed [CRD_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic                    zero_reg;
    logic signed [CRD_W-1:0] xe, ye, xs, ys;
    logic signed [Z_W-1:0]   at;

    assign xe = CRD_W'(x_in);
    assign ye = CRD_W'(y_in);
    assign xs = x_reg >>> iter;
    assign ys = y_reg >>> iter;
    assign at = atan_lookup(iter);

    always_ff @(posedge aclk) begin
        if (load) begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            // left half plane: rotate by a quarter turn first
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg <= ye;
                    y_reg <= -xe;
                    z_reg <= Z_HALF_PI;
                end else begin
                    x_reg <= -ye;
                    y_reg <= xe;
                    z_reg <= -Z_HALF_PI;
                end
            end else begin
                x_reg <= xe;
                y_reg <= ye;
                z_reg <= '0;
            end
        end else if (step) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    // both operands zero gives angle zero
    assign z_out = zero_reg ? '0 : z_reg;

endmodule

// File: hdl/qte_dp.sv
// datapath: product terms, sums, square root and cordic, angle rounding
// depends on qte_pkg, qte_cordic, qte_isqrt
module qte_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qte_pkg::dp_cmd_t                    cmd,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_z,
    input  logic signed [qte_pkg::QUAT_W-1:0]   quat_w,
    output qte_pkg::dp_stat_t                   stat,
    output logic signed [qte_pkg::ANG_W-1:0]    angle_x,
    output logic signed [qte_pkg::ANG_W-1:0]    angle_y,
    output logic signed [qte_pkg::ANG_W-1:0]    angle_z
);
    import qte_pkg::*;

    logic signed [QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [ACC_W-1:0]  nx_reg, dx_reg, ny_reg, dy_reg, s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    term_t                    tag_reg;
    logic                     prod_vld_reg, prod_vld_next;
    logic signed [ANG_W-1:0]  ang_x_reg, ang_y_reg, ang_z_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  p2;
    logic signed [ACC_W-1:0]  crd_y, crd_x;
    logic signed [Z_W-1:0]    crd_z;
    logic signed [Z_W-1:0]    bam;
    logic [RAD_W-1:0]         rad;
    logic [ROOT_W-1:0]        root;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = MUL_W'(qw_reg);
        mul_b = MUL_W'(qx_reg);
        case (cmd.term)
            TERM_WX:   begin mul_a = MUL_W'(qw_reg); mul_b = MUL_W'(qx_reg); end
            TERM_YZ:   begin mul_a = MUL_W'(qy_reg); mul_b = MUL_W'(qz_reg); end
            TERM_XX:   begin mul_a = MUL_W'(qx_reg); mul_b = MUL_W'(qx_reg); end
            TERM_ZZ_X: begin mul_a = MUL_W'(qz_reg); mul_b = MUL_W'(qz_reg); end
            TERM_WY:   begin mul_a = MUL_W'(qw_reg); mul_b = MUL_W'(qy_reg); end
            TERM_XZ:   begin mul_a = MUL_W'(qx_reg); mul_b = MUL_W'(qz_reg); end
            TERM_YY:   begin mul_a = MUL_W'(qy_reg); mul_b = MUL_W'(qy_reg); end
            TERM_ZZ_Y: begin mul_a = MUL_W'(qz_reg); mul_b = MUL_W'(qz_reg); end
            TERM_WZ:   begin mul_a = MUL_W'(qw_reg); mul_b = MUL_W'(qz_reg); end
            TERM_YX:   begin mul_a = MUL_W'(qy_reg); mul_b = MUL_W'(qx_reg); end
            TERM_SS:   begin
                mul_a = $signed(s_reg[MUL_W-1:0]);
                mul_b = $signed(s_reg[MUL_W-1:0]);
            end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // twice the registered product
    assign p2 = $signed({prod_reg[ACC_W-2:0], 1'b0});

    assign prod_vld_next = cmd.mul_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
            tag_reg  <= cmd.term;
        end
    end

    // running sums in q.28
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nx_reg <= '0;
            dx_reg <= ONE_Q28;
            ny_reg <= '0;
            dy_reg <= ONE_Q28;
            s_reg  <= '0;
        end else if (prod_vld_reg) begin
            case (tag_reg)
                TERM_WX, TERM_YZ:   nx_reg <= nx_reg + p2;
                TERM_XX, TERM_ZZ_X: dx_reg <= dx_reg - p2;
                TERM_WY, TERM_XZ:   ny_reg <= ny_reg + p2;
                TERM_YY, TERM_ZZ_Y: dy_reg <= dy_reg - p2;
                TERM_WZ:            s_reg  <= s_reg + p2;
                TERM_YX:            s_reg  <= s_reg - p2;
                default:            ;
            endcase
        end
    end

    assign stat.asin_sat = (s_reg >= ONE_Q28) || (s_reg <= -ONE_Q28);

    // radicand 1 - s^2 in q.56
    assign rad = RAD_ONE - RAD_W'(prod_reg);

    qte_isqrt u_isqrt (
        .aclk   (aclk),
        .load   (cmd.sqrt_load),
        .step   (cmd.sqrt_step),
        .rad_in (rad),
        .root   (root)
    );

    always_comb begin
        crd_y = nx_reg;
        crd_x = dx_reg;
        case (cmd.src)
            SRC_X:   begin crd_y = nx_reg; crd_x = dx_reg; end
            SRC_Y:   begin crd_y = ny_reg; crd_x = dy_reg; end
            SRC_Z:   begin crd_y = s_reg;  crd_x = $signed({{(ACC_W-ROOT_W){1'b0}}, root}); end
            default: begin crd_y = '0;     crd_x = '0; end
        endcase
    end

    qte_cordic u_cordic (
        .aclk  (aclk),
        .load  (cmd.crd_load),
        .step  (cmd.crd_step),
        .iter  (cmd.iter),
        .y_in  (crd_y),
        .x_in  (crd_x),
        .z_out (crd_z)
    );

    // round half up to 16-bit binary angle
    assign bam = (crd_z + BAM_ROUND) >>> 16;

    always_ff @(posedge aclk) begin
        if (cmd.res_sat) begin
            ang_z_reg <= (s_reg > 0) ? ANG_PI_2 : -ANG_PI_2;
        end else if (cmd.res_save) begin
            case (cmd.src)
                SRC_X: ang_x_reg <= bam[ANG_W-1:0];
                SRC_Y: ang_y_reg <= bam[ANG_W-1:0];
                SRC_Z: begin
                    if (bam > Z_ANG_MAX) begin
                        ang_z_reg <= ANG_PI_2;
                    end else if (bam < -Z_ANG_MAX) begin
                        ang_z_reg <= -ANG_PI_2;
                    end else begin
                        ang_z_reg <= bam[ANG_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign angle_x = ang_x_reg;
    assign angle_y = ang_y_reg;
    assign angle_z = ang_z_reg;

endmodule

// File: hdl/qte_ctrl.sv
// controller: sequences products, cordic passes and the square root
// depends on qte_pkg
module qte_ctrl #(
    parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               out_free,
    output logic               out_load,
    input  qte_pkg::dp_stat_t  stat,
    output qte_pkg::dp_cmd_t   cmd
);
    import qte_pkg::*;

    localparam int CNT_W = ($clog2(CORDIC_ITERATIONS) > ATAN_IDX_W) ?
                           $clog2(CORDIC_ITERATIONS) : ATAN_IDX_W;
    localparam logic [CNT_W-1:0] CNT_ITER_LAST = CNT_W'(CORDIC_ITERATIONS - 1);
    localparam logic [CNT_W-1:0] CNT_SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_TERM_LAST = CNT_W'(TERM_YX);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL   = 10'b00_0000_0010,
        ST_ACC   = 10'b00_0000_0100,
        ST_CLOAD = 10'b00_0000_1000,
        ST_CRUN  = 10'b00_0001_0000,
        ST_CSAVE = 10'b00_0010_0000,
        ST_ACHK  = 10'b00_0100_0000,
        ST_SQW   = 10'b00_1000_0000,
        ST_SQRT  = 10'b01_0000_0000,
        ST_FIN   = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    src_t             src_reg, src_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            src_reg   <= SRC_X;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            src_reg   <= src_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        cmd.src    = src_reg;
        cmd.iter   = cnt_reg[ATAN_IDX_W-1:0];
        cmd.term   = term_t'(cnt_reg[TERM_W-1:0]);
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == CNT_TERM_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_ACC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ACC: begin
                src_next   = SRC_X;
                state_next = ST_CLOAD;
            end
            ST_CLOAD: begin
                cmd.crd_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_CRUN;
            end
            ST_CRUN: begin
                cmd.crd_step = 1'b1;
                if (cnt_reg == CNT_ITER_LAST) begin
                    state_next = ST_CSAVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CSAVE: begin
                cmd.res_save = 1'b1;
                case (src_reg)
                    SRC_X: begin
                        src_next   = SRC_Y;
                        state_next = ST_CLOAD;
                    end
                    SRC_Y:   state_next = ST_ACHK;
                    default: state_next = ST_FIN;
                endcase
            end
            ST_ACHK: begin
                if (stat.asin_sat) begin
                    cmd.res_sat = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    cmd.mul_en = 1'b1;
                    cmd.term   = TERM_SS;
                    state_next = ST_SQW;
                end
            end
            ST_SQW: begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_SQRT_LAST) begin
                    src_next   = SRC_Z;
                    state_next = ST_CLOAD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/quaternion_to_euler_angles_top.sv
// top level of the quaternion to euler angle converter
// depends on qte_pkg, qte_ctrl, qte_dp (with qte_cordic, qte_isqrt)
//
//   channel | ports                              | direction | transaction
//   --------+------------------------------------+-----------+---------------------
//   s_      | s_valid s_ready s_quat_x/y/z/w     | in        | one quaternion q2.14
//   m_      | m_valid m_ready m_angle_x/y/z      | out       | three binary angles
//
// one transaction at a time: the controller walks ten product terms through one
// shared multiplier, then three vectoring cordic passes of CORDIC_ITERATIONS steps
// each with a 29-step square root before the last one; when the arcsine argument
// saturates, the square root and the last pass are skipped
// reset (aresetn low, synchronous) empties the result register and idles the fsm
// a held result in the output register keeps the fsm in its final state, so the
// next quaternion is not accepted until the result slot frees
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [qte_pkg::QUAT_W-1:0]   s_quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0]   s_quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0]   s_quat_z,
    input  logic signed [qte_pkg::QUAT_W-1:0]   s_quat_w,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qte_pkg::ANG_W-1:0]    m_angle_x,
    output logic signed [qte_pkg::ANG_W-1:0]    m_angle_y,
    output logic signed [qte_pkg::ANG_W-1:0]    m_angle_z
);
    import qte_pkg::*;

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic                    out_free;
    logic                    out_load;
    logic signed [ANG_W-1:0] res_x, res_y, res_z;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic signed [ANG_W-1:0] m_angle_x_reg, m_angle_y_reg, m_angle_z_reg;

    // slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    qte_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    qte_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .quat_x  (s_quat_x),
        .quat_y  (s_quat_y),
        .quat_z  (s_quat_z),
        .quat_w  (s_quat_w),
        .stat    (stat),
        .angle_x (res_x),
        .angle_y (res_y),
        .angle_z (res_z)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload only moves on a load, so it holds while stalled
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_angle_x_reg <= res_x;
            m_angle_y_reg <= res_y;
            m_angle_z_reg <= res_z;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_angle_x = m_angle_x_reg;
    assign m_angle_y = m_angle_y_reg;
    assign m_angle_z = m_angle_z_reg;

endmodule

// File: hdl/qte_checker.sv
// port-level checker for the quaternion to euler angle block, bound to the top
// depends on quaternion_to_euler_angles_top_assert.svh
`include "quaternion_to_euler_angles_top_assert.svh"

module qte_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [15:0] s_quat_x,
    input logic signed [15:0] s_quat_y,
    input logic signed [15:0] s_quat_z,
    input logic signed [15:0] s_quat_w,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_angle_x,
    input logic signed [15:0] m_angle_y,
    input logic signed [15:0] m_angle_z
);

    // stalled result holds
    `QTE_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_angle_x) && $stable(m_angle_y) && $stable(m_angle_z))

    // arcsine result stays within a quarter turn
    `QTE_ASSERT_IMP(a_z_range, m_valid, (m_angle_z >= -16'sd16384) && (m_angle_z <= 16'sd16384))

    // one transaction at a time: busy right after an accept
    `QTE_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // a new result appears only as the controller returns to idle
    `QTE_ASSERT_IMP(a_idle_on_result, $rose(m_valid), s_ready)

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);

// File: bench/euler_angle_checker.sv
`timescale 1ns / 1ps
// watches both channels of the quaternion to euler angle block, predicts the
// three binary angles of each accepted quaternion and compares the results
// uses qte_pkg for widths and the default iteration count only
module euler_angle_checker #(
    parameter int ITERATIONS = qte_pkg::CORDIC_ITER_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [qte_pkg::QUAT_W-1:0] s_quat_x,
    input  logic signed [qte_pkg::QUAT_W-1:0] s_quat_y,
    input  logic signed [qte_pkg::QUAT_W-1:0] s_quat_z,
    input  logic signed [qte_pkg::QUAT_W-1:0] s_quat_w,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [qte_pkg::ANG_W-1:0]  m_angle_x,
    input  logic signed [qte_pkg::ANG_W-1:0]  m_angle_y,
    input  logic signed [qte_pkg::ANG_W-1:0]  m_angle_z,
    output int                                pending,
    output int                                fail_count
);

    typedef struct packed {
        logic signed [qte_pkg::ANG_W-1:0] x;
        logic signed [qte_pkg::ANG_W-1:0] y;
        logic signed [qte_pkg::ANG_W-1:0] z;
    } euler_t;

    localparam longint ONE_Q28 = longint'(1) << 28;

    // atan(2^-i), pi = 2^31
    localparam longint ATAN_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    euler_t expected_angles[$];

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // vectoring rotation toward the positive x axis, angle in 2^31 = pi
    function automatic longint vector_angle(longint num, longint den);
        longint acc;
        longint tmp;
        longint dx;
        longint dy;
        int     steps;
        acc = 0;
        if (num == 0 && den == 0) return 0;
        if (den < 0) begin
            tmp = den;
            if (num >= 0) begin
                den = num;
                num = -tmp;
                acc = longint'(1) << 30;
            end else begin
                den = -num;
                num = tmp;
                acc = -(longint'(1) << 30);
            end
        end
        steps = (ITERATIONS > 24) ? 24 : ((ITERATIONS < 0) ? 0 : ITERATIONS);
        for (int i = 0; i < steps; i++) begin
            dx = den >>> i;
            dy = num >>> i;
            if (num > 0) begin
                den = den + dy;
                num = num - dx;
                acc = acc + ATAN_STEP[i];
            end else begin
                den = den - dy;
                num = num + dx;
                acc = acc - ATAN_STEP[i];
            end
        end
        return acc;
    endfunction

    // round half up to 16-bit binary angle
    function automatic longint to_bam(longint acc);
        return (acc + 32768) >>> 16;
    endfunction

    function automatic euler_t predict_angles(longint qx, longint qy, longint qz, longint qw);
        euler_t          res;
        longint          nx, dx, ny, dy, s, ax, ay, az, c;
        longint unsigned rem;
        nx = 2 * (qw * qx + qy * qz);
        dx = ONE_Q28 - 2 * (qx * qx + qz * qz);
        ny = 2 * (qw * qy + qx * qz);
        dy = ONE_Q28 - 2 * (qy * qy + qz * qz);
        s  = 2 * (qw * qz - qy * qx);
        ax = to_bam(vector_angle(nx, dx));
        ay = to_bam(vector_angle(ny, dy));
        if (s >= ONE_Q28) begin
            az = 16384;
        end else if (s <= -ONE_Q28) begin
            az = -16384;
        end else begin
            // asin(s) as atan2(s, sqrt(1 - s^2))
            rem = (64'd1 << 56) - longint'(s * s);
            c   = longint'(root_floor(rem));
            az  = to_bam(vector_angle(s, c));
            if (az > 16384) az = 16384;
            if (az < -16384) az = -16384;
        end
        res.x = qte_pkg::ANG_W'(ax);
        res.y = qte_pkg::ANG_W'(ay);
        res.z = qte_pkg::ANG_W'(az);
        return res;
    endfunction

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    always @(posedge aclk) begin
        euler_t want;
        if (!aresetn) begin
            expected_angles.delete();
        end else begin
            // results first, so a stray result never meets a fresh expectation
            if (m_valid && m_ready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t unexpected result: actual %0d %0d %0d", $time,
                             m_angle_x, m_angle_y, m_angle_z);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_angles.pop_front();
                    if (m_angle_x !== want.x || m_angle_y !== want.y ||
                        m_angle_z !== want.z) begin
                        $display("%0t angle mismatch: expected %0d %0d %0d actual %0d %0d %0d",
                                 $time, want.x, want.y, want.z,
                                 m_angle_x, m_angle_y, m_angle_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_angles.push_back(predict_angles(longint'(s_quat_x),
                    longint'(s_quat_y), longint'(s_quat_z), longint'(s_quat_w)));
        end
        pending <= expected_angles.size();
    end

endmodule

// File: bench/quaternion_to_euler_angles_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the quaternion to euler angle converter: makes quaternion
// transactions, drives the result ready and gives the verdict
// depends on qte_pkg, quaternion_to_euler_angles_top and euler_angle_checker
module quaternion_to_euler_angles_top_tb;

    localparam int ITERATIONS = qte_pkg::CORDIC_ITER_DEF;
    localparam int RANDOM_QUATS = 1330;
    // covers the longest accept-to-result time, padded
    localparam int SETTLE_CYCLES = 3 * ITERATIONS + 70;
    // room for every transaction plus gaps and stalls, taken several times over
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_STALL = 600;

    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_valid  = 1'b0;
    logic                              s_ready;
    logic signed [qte_pkg::QUAT_W-1:0] s_quat_x = '0;
    logic signed [qte_pkg::QUAT_W-1:0] s_quat_y = '0;
    logic signed [qte_pkg::QUAT_W-1:0] s_quat_z = '0;
    logic signed [qte_pkg::QUAT_W-1:0] s_quat_w = '0;
    logic                              m_valid;
    logic                              m_ready  = 1'b0;
    logic signed [qte_pkg::ANG_W-1:0]  m_angle_x;
    logic signed [qte_pkg::ANG_W-1:0]  m_angle_y;
    logic signed [qte_pkg::ANG_W-1:0]  m_angle_z;

    int pending;
    int fail_count;
    int tx_idle_pct = 19;
    int rx_idle_pct = 82;
    bit stall_req   = 1'b0;
    int cycle_cnt   = 0;

    quaternion_to_euler_angles_top #(
        .CORDIC_ITERATIONS(ITERATIONS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_quat_x  (s_quat_x),
        .s_quat_y  (s_quat_y),
        .s_quat_z  (s_quat_z),
        .s_quat_w  (s_quat_w),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_angle_x (m_angle_x),
        .m_angle_y (m_angle_y),
        .m_angle_z (m_angle_z)
    );

    euler_angle_checker #(
        .ITERATIONS(ITERATIONS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_quat_x   (s_quat_x),
        .s_quat_y   (s_quat_y),
        .s_quat_z   (s_quat_z),
        .s_quat_w   (s_quat_w),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_angle_x  (m_angle_x),
        .m_angle_y  (m_angle_y),
        .m_angle_z  (m_angle_z),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("%0t timeout after %0d cycles", $time, cycle_cnt);
        $display("tb: failure");
        $finish;
    end

    // result side: random ready, or one long hold-off on request so the
    // block backs up and drops s_ready while transactions keep coming
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge aclk);
            end else begin
                m_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
            end
        end
    end

    // one quaternion transaction: random gap, then hold valid until accepted
    task automatic offer_quat(input int qx, input int qy, input int qz, input int qw);
        @(negedge aclk);
        while (int'($urandom_range(99)) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_quat_x <= qte_pkg::QUAT_W'(qx);
        s_quat_y <= qte_pkg::QUAT_W'(qy);
        s_quat_z <= qte_pkg::QUAT_W'(qz);
        s_quat_w <= qte_pkg::QUAT_W'(qw);
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait for every outstanding result
    task automatic idle_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic int pick_component(int mode);
        int v;
        case (mode)
            // whole 16-bit pattern, walks every bit
            0: v = int'($urandom_range(65535)) - 32768;
            // anywhere in the nominal q2.14 range
            1: v = int'($urandom_range(32768)) - 16384;
            // small values, away from the saturation corners
            2: v = int'($urandom_range(4096)) - 2048;
            default: begin
                case ($urandom_range(5))
                    0: v = -32768;
                    1: v = -16384;
                    2: v = 0;
                    3: v = 16384;
                    4: v = 32767;
                    default: v = int'($urandom_range(65535)) - 32768;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin : stimulus
        int q[4];
        int sel;
        int dom;

        // synchronous reset, then release
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        offer_quat(0, 0, 0, 16384);              // identity
        offer_quat(0, 0, 0, 0);                  // all-zero quaternion
        offer_quat(16384, 0, 0, 0);              // angle x of pi wraps negative
        offer_quat(0, 16384, 0, 0);              // angle y of pi
        offer_quat(0, 0, 16384, 0);              // both atan2 at pi
        offer_quat(0, 0, 16384, 8192);           // asin argument exactly +1
        offer_quat(0, 0, -16384, 8192);          // asin argument exactly -1
        offer_quat(0, 0, 16384, 16384);          // asin argument beyond +1
        offer_quat(0, 0, -16384, 16384);         // asin argument beyond -1
        offer_quat(0, 0, 16384, 8191);           // just under +1, rounding clamp
        offer_quat(0, 0, -16384, 8191);          // just under -1
        offer_quat(-32768, -32768, -32768, -32768);
        offer_quat(32767, 32767, 32767, 32767);
        offer_quat(-32768, 32767, -32768, 32767);
        offer_quat(16384, 16384, 16384, 16384);
        offer_quat(-16384, -16384, -16384, -16384);
        offer_quat(11585, 0, 0, 11585);          // quarter turn about x
        offer_quat(0, 11585, 0, -11585);
        offer_quat(0, 0, 11585, 11585);
        offer_quat(1, 0, 0, 0);
        offer_quat(0, -1, 0, 0);
        offer_quat(-16384, 16384, -16384, 16384);
        offer_quat(0, 0, 0, -32768);
        offer_quat(-12000, 0, 0, 4000);          // third quadrant pre-rotation

        for (int n = 0; n < RANDOM_QUATS; n++) begin
            // idle phases: light sender gaps with heavy receiver stalls first, then heavy
            // sender gaps with light receiver stalls, then full rate both ways
            if (n == RANDOM_QUATS / 3) begin
                tx_idle_pct = 82;
                rx_idle_pct = 19;
            end
            if (n == 2 * RANDOM_QUATS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // sender waits for the pipe to empty once
            if (n == 600)
                idle_until_drained();
            // receiver holds off for a long stretch while we keep pushing
            if (n == 1000)
                stall_req = 1'b1;

            sel = int'($urandom_range(99));
            if (sel < 20) begin
                foreach (q[i]) q[i] = pick_component(0);
            end else if (sel < 55) begin
                foreach (q[i]) q[i] = pick_component(1);
            end else if (sel < 75) begin
                foreach (q[i]) q[i] = pick_component(2);
            end else if (sel < 90) begin
                // one dominant component near unit magnitude
                dom = int'($urandom_range(3));
                foreach (q[i]) begin
                    if (i == dom)
                        q[i] = ($urandom_range(1) ? 1 : -1) *
                               int'($urandom_range(16384, 14000));
                    else
                        q[i] = int'($urandom_range(6000)) - 3000;
                end
            end else begin
                foreach (q[i]) q[i] = pick_component(3);
            end
            offer_quat(q[0], q[1], q[2], q[3]);
        end

        idle_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
